// ===== design/swsl_pkg.sv =====
// Shared types and constants of the sliding-window sound level statistics block.
`timescale 1ns / 1ps

package swsl_pkg;

    localparam int LEVEL_W   = 11;
    localparam int FILL_W    = 14;
    localparam int CAL_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int HIST_DEPTH = 2048;
    localparam int HIST_AW   = 11;
    localparam int DIV_NUM_W = 46;
    localparam int DIV_CNT_W = 6;
    localparam int SUM_W     = 46;
    localparam int OUT_DATA_W = 64;
    localparam int RANK_SHIFT = 35;

    localparam logic [CFG_IDX_W-1:0] CFG_MIC_BIAS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_OFFSET = 2'd2;

    localparam logic [11:0]       MIC_BIAS_RESET   = 12'd1920;
    localparam logic [FILL_W-1:0] WINDOW_LEN_RESET = 14'd7200;
    localparam logic [CAL_W-1:0]  CAL_OFFSET_RESET = 11'd319;

    localparam logic [31:0] ONE_Q30       = 32'd1073741824;
    localparam logic [31:0] LVL_PER_LOG2  = 32'd6313057;
    localparam logic [31:0] LEQ_PER_LOG2  = 32'd3156528;
    localparam logic [31:0] DB_TO_LOG2_Q8 = 32'd348329;
    localparam logic [31:0] RANK_RECIP    = 32'd3435973837;
    localparam logic [20:0] LOG2_Q16_30   = 21'(30 << 16);

    typedef enum logic [4:0] {
        S_IDLE, S_HCLR, S_LNORM, S_LSQ, S_LSQW, S_LVM, S_LVW,
        S_P1RD, S_P1ST, S_P1HW, S_RANK, S_RANKW,
        S_SRD, S_SDAT, S_SX, S_SCH, S_SCHW, S_SSH, S_SMUL, S_SACC,
        S_MEAN, S_MEANW, S_LEQM, S_LEQW, S_DONE
    } state_t;

    typedef enum logic {
        LOG_LEVEL,
        LOG_LEQ
    } log_sel_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [FILL_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [31:0] exp_chain(input logic [2:0] k);
        logic [31:0] c;
        case (k)
            3'd0:    c = 32'd759250125;
            3'd1:    c = 32'd902905651;
            3'd2:    c = 32'd984625594;
            3'd3:    c = 32'd1028218693;
            3'd4:    c = 32'd1050733751;
            3'd5:    c = 32'd1062175488;
            3'd6:    c = 32'd1067943006;
            default: c = 32'd1070838491;
        endcase
        return c;
    endfunction

endpackage

// ===== design/swsl_mul.sv =====
// Shared 32x32 unsigned multiplier with registered product.
`timescale 1ns / 1ps

module swsl_mul
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(a) * 64'(b);
    end

    assign prod = prod_reg;

endmodule

// ===== design/swsl_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module swsl_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  swsl_pkg::div_req_t             req,
    output swsl_pkg::div_stat_t            stat,
    output logic [swsl_pkg::DIV_NUM_W-1:0] quotient
);

    import swsl_pkg::*;

    logic [DIV_NUM_W-1:0] quot_reg, quot_next;
    logic [FILL_W-1:0]    rem_reg, rem_next;
    logic [FILL_W-1:0]    dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [FILL_W:0]      rem_sh;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, quot_reg[DIV_NUM_W-1]};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_next  = FILL_W'(rem_sh - {1'b0, dsr_reg});
                quot_next = {quot_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[FILL_W-1:0];
                quot_next = {quot_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quot_reg;

endmodule

// ===== design/swsl_core.sv =====
// Sequencer, level store, histogram and datapath of the sound level statistics.
`timescale 1ns / 1ps

module swsl_core
#(
    parameter int WINDOW_DEPTH = 8192,
    parameter int ADC_BITS     = 12
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [ADC_BITS-1:0]                    in_sample,
    input  logic [(ADC_BITS > 12 ? ADC_BITS : 12)-1:0] mic_bias,
    input  logic [swsl_pkg::FILL_W-1:0]            window_len,
    input  logic signed [swsl_pkg::CAL_W-1:0]      cal_offset,
    output logic                                   res_valid,
    input  logic                                   res_ready,
    output logic [swsl_pkg::LEVEL_W-1:0]           res_sample_level,
    output logic [swsl_pkg::LEVEL_W-1:0]           res_leq_level,
    output logic [swsl_pkg::LEVEL_W-1:0]           res_max_level,
    output logic [swsl_pkg::LEVEL_W-1:0]           res_l10_level,
    output logic [swsl_pkg::FILL_W-1:0]            res_fill_count
);

    import swsl_pkg::*;

    localparam int BIAS_W = (ADC_BITS > 12) ? ADC_BITS : 12;
    localparam int SAW    = $clog2(WINDOW_DEPTH);

    state_t   state_reg, state_next;
    log_sel_t log_sel_reg, log_sel_next;

    logic [SAW-1:0]     wp_reg, wp_next;
    logic [SAW-1:0]     rd_idx_reg, rd_idx_next;
    logic [FILL_W-1:0]  count_reg, count_next;
    logic [FILL_W-1:0]  rem_reg, rem_next;
    logic [LEVEL_W-1:0] maxl_reg, maxl_next;
    logic [LEVEL_W-1:0] cur_lvl_reg, cur_lvl_next;
    logic [LEVEL_W-1:0] lvl_reg, lvl_next;
    logic [LEVEL_W-1:0] leq_reg, leq_next;
    logic [LEVEL_W-1:0] l10_reg, l10_next;
    logic [31:0]        lm_reg, lm_next;
    logic [4:0]         le_reg, le_next;
    logic [15:0]        lfrac_reg, lfrac_next;
    logic [3:0]         lit_reg, lit_next;
    logic [HIST_AW-1:0] hv_reg, hv_next;
    logic [FILL_W-1:0]  acc_reg, acc_next;
    logic [FILL_W-1:0]  rank_reg, rank_next;
    logic               found_reg, found_next;
    logic [FILL_W-1:0]  h_reg, h_next;
    logic [5:0]         ip_reg, ip_next;
    logic [7:0]         fr_reg, fr_next;
    logic [3:0]         k_reg, k_next;
    logic [30:0]        w_reg, w_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;

    logic [LEVEL_W-1:0] store [WINDOW_DEPTH];
    logic [LEVEL_W-1:0] st_rdata_reg;
    logic               st_we;
    logic [FILL_W-1:0]  hist [HIST_DEPTH];
    logic [FILL_W-1:0]  hist_rdata_reg;
    logic               hist_we;
    logic [HIST_AW-1:0] hist_waddr;
    logic [FILL_W-1:0]  hist_wdata;
    logic [HIST_AW-1:0] hist_raddr;

    logic [31:0]          mul_a, mul_b;
    logic [63:0]          prod;
    div_req_t             div_req;
    div_stat_t            div_stat;
    logic [DIV_NUM_W-1:0] quotient;

    logic [BIAS_W-1:0]    sample_ext, amp;
    logic [FILL_W-1:0]    len_eff;
    logic [FILL_W:0]      count_inc;
    logic [12:0]          raw_lvl;
    logic signed [13:0]   lvl_s;
    logic [FILL_W-1:0]    acc_sum;
    logic [13:0]          x_val;
    logic [31:0]          sq;
    logic [11:0]          red;
    logic [20:0]          neg;
    logic [DIV_NUM_W-1:0] mean;

    swsl_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    swsl_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store[wp_reg] <= lvl_next;
        end
        st_rdata_reg <= store[rd_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist[hist_waddr] <= hist_wdata;
        end
        hist_rdata_reg <= hist[hist_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_HCLR;
            S_HCLR:  if (hv_reg == HIST_AW'(HIST_DEPTH - 1)) state_next = S_LNORM;
            S_LNORM: if (lm_reg[30] || le_reg == 5'd0) state_next = S_LSQ;
            S_LSQ:   state_next = S_LSQW;
            S_LSQW:
            begin
                if (lit_reg == 4'd15)
                begin
                    state_next = (log_sel_reg == LOG_LEVEL) ? S_LVM : S_LEQM;
                end
                else
                begin
                    state_next = S_LSQ;
                end
            end
            S_LVM:   state_next = S_LVW;
            S_LVW:   state_next = S_P1RD;
            S_P1RD:  state_next = S_P1ST;
            S_P1ST:  state_next = S_P1HW;
            S_P1HW:  state_next = (rem_reg == FILL_W'(1)) ? S_RANK : S_P1RD;
            S_RANK:  state_next = S_RANKW;
            S_RANKW: state_next = S_SRD;
            S_SRD:   state_next = S_SDAT;
            S_SDAT:
            begin
                if (hist_rdata_reg != '0)
                begin
                    state_next = S_SX;
                end
                else if (hv_reg == HIST_AW'(HIST_DEPTH - 1))
                begin
                    state_next = S_MEAN;
                end
                else
                begin
                    state_next = S_SRD;
                end
            end
            S_SX:    state_next = S_SCH;
            S_SCH:
            begin
                if (k_reg == 4'd8)
                begin
                    state_next = S_SSH;
                end
                else if (fr_reg[3'd7 - k_reg[2:0]])
                begin
                    state_next = S_SCHW;
                end
            end
            S_SCHW:  state_next = S_SCH;
            S_SSH:   state_next = S_SMUL;
            S_SMUL:  state_next = S_SACC;
            S_SACC:  state_next = (hv_reg == HIST_AW'(HIST_DEPTH - 1)) ? S_MEAN : S_SRD;
            S_MEAN:  state_next = S_MEANW;
            S_MEANW: if (div_stat.done) state_next = S_LNORM;
            S_LEQM:  state_next = S_LEQW;
            S_LEQW:  state_next = S_DONE;
            S_DONE:  if (res_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        log_sel_next = log_sel_reg;
        wp_next      = wp_reg;
        rd_idx_next  = rd_idx_reg;
        count_next   = count_reg;
        rem_next     = rem_reg;
        maxl_next    = maxl_reg;
        cur_lvl_next = cur_lvl_reg;
        lvl_next     = lvl_reg;
        leq_next     = leq_reg;
        l10_next     = l10_reg;
        lm_next      = lm_reg;
        le_next      = le_reg;
        lfrac_next   = lfrac_reg;
        lit_next     = lit_reg;
        hv_next      = hv_reg;
        acc_next     = acc_reg;
        rank_next    = rank_reg;
        found_next   = found_reg;
        h_next       = h_reg;
        ip_next      = ip_reg;
        fr_next      = fr_reg;
        k_next       = k_reg;
        w_next       = w_reg;
        sum_next     = sum_reg;

        st_we      = 1'b0;
        hist_we    = 1'b0;
        hist_waddr = hv_reg;
        hist_wdata = '0;
        hist_raddr = hv_reg;
        mul_a      = '0;
        mul_b      = '0;
        div_req    = '0;

        sample_ext = BIAS_W'(in_sample);
        amp = (sample_ext >= mic_bias) ? sample_ext - mic_bias : mic_bias - sample_ext;
        if (amp == '0)
        begin
            amp = BIAS_W'(1);
        end

        if (window_len == '0)
        begin
            len_eff = FILL_W'(1);
        end
        else if (32'(window_len) > WINDOW_DEPTH)
        begin
            len_eff = FILL_W'(WINDOW_DEPTH);
        end
        else
        begin
            len_eff = window_len;
        end
        count_inc = {1'b0, count_reg} + 1'b1;

        raw_lvl = 13'(prod[43:32]) + 13'(prod[31]);
        lvl_s   = 14'(cal_offset) + $signed({1'b0, raw_lvl});
        acc_sum = acc_reg + hist_rdata_reg;
        x_val   = 14'(prod[31:16]) + 14'(prod[15]);
        sq      = prod[61:30];
        red     = 12'(prod[63:32]) + 12'(prod[31]);
        neg     = LOG2_Q16_30 - {le_reg, lfrac_reg};
        mean    = quotient;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    lm_next      = 32'(amp);
                    le_next      = 5'd30;
                    lfrac_next   = '0;
                    lit_next     = '0;
                    log_sel_next = LOG_LEVEL;
                    hv_next      = '0;
                end
            end
            S_HCLR:
            begin
                hist_we = 1'b1;
                hv_next = hv_reg + 1'b1;
            end
            S_LNORM:
            begin
                if (!lm_reg[30] && le_reg != 5'd0)
                begin
                    lm_next = {lm_reg[30:0], 1'b0};
                    le_next = le_reg - 1'b1;
                end
            end
            S_LSQ:
            begin
                mul_a = {1'b0, lm_reg[30:0]};
                mul_b = {1'b0, lm_reg[30:0]};
            end
            S_LSQW:
            begin
                lm_next    = sq[31] ? {1'b0, sq[31:1]} : sq;
                lfrac_next = {lfrac_reg[14:0], sq[31]};
                lit_next   = lit_reg + 1'b1;
            end
            S_LVM:
            begin
                mul_a = 32'({le_reg, lfrac_reg});
                mul_b = LVL_PER_LOG2;
            end
            S_LVW:
            begin
                if (lvl_s < 0)
                begin
                    lvl_next = '0;
                end
                else if (lvl_s > 14'sd2047)
                begin
                    lvl_next = '1;
                end
                else
                begin
                    lvl_next = lvl_s[LEVEL_W-1:0];
                end
                st_we = 1'b1;
                wp_next = (wp_reg == SAW'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                count_next = (count_inc > {1'b0, len_eff}) ? len_eff : count_inc[FILL_W-1:0];
                rem_next    = count_next;
                rd_idx_next = wp_reg;
                maxl_next   = '0;
            end
            S_P1ST:
            begin
                cur_lvl_next = st_rdata_reg;
                hist_raddr   = st_rdata_reg;
                if (st_rdata_reg > maxl_reg)
                begin
                    maxl_next = st_rdata_reg;
                end
            end
            S_P1HW:
            begin
                hist_we     = 1'b1;
                hist_waddr  = cur_lvl_reg;
                hist_wdata  = hist_rdata_reg + 1'b1;
                rem_next    = rem_reg - 1'b1;
                rd_idx_next = (rd_idx_reg == '0) ? SAW'(WINDOW_DEPTH - 1) : rd_idx_reg - 1'b1;
            end
            S_RANK:
            begin
                mul_a = 32'({count_reg, 3'b000}) + 32'(count_reg);
                mul_b = RANK_RECIP;
            end
            S_RANKW:
            begin
                rank_next  = prod[RANK_SHIFT +: FILL_W];
                hv_next    = '0;
                acc_next   = '0;
                found_next = 1'b0;
                sum_next   = '0;
                l10_next   = maxl_reg;
            end
            S_SDAT:
            begin
                h_next   = hist_rdata_reg;
                acc_next = acc_sum;
                if (!found_reg && acc_sum > rank_reg)
                begin
                    found_next = 1'b1;
                    l10_next   = hv_reg;
                end
                if (hist_rdata_reg != '0)
                begin
                    mul_a = 32'(maxl_reg - hv_reg);
                    mul_b = DB_TO_LOG2_Q8;
                end
                else
                begin
                    hv_next = hv_reg + 1'b1;
                end
            end
            S_SX:
            begin
                ip_next = x_val[13:8];
                fr_next = x_val[7:0];
                k_next  = '0;
                w_next  = ONE_Q30[30:0];
            end
            S_SCH:
            begin
                mul_a = {1'b0, w_reg};
                mul_b = exp_chain(k_reg[2:0]);
                if (k_reg != 4'd8 && !fr_reg[3'd7 - k_reg[2:0]])
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_SCHW:
            begin
                w_next = 31'(prod[60:30]) + 31'(prod[29]);
                k_next = k_reg + 1'b1;
            end
            S_SSH:
            begin
                w_next = (ip_reg >= 6'd31) ? '0 : w_reg >> ip_reg;
            end
            S_SMUL:
            begin
                mul_a = {1'b0, w_reg};
                mul_b = 32'(h_reg);
            end
            S_SACC:
            begin
                sum_next = sum_reg + prod[SUM_W-1:0];
                hv_next  = hv_reg + 1'b1;
            end
            S_MEAN:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = sum_reg;
                div_req.divisor  = count_reg;
            end
            S_MEANW:
            begin
                if (div_stat.done)
                begin
                    if (mean == '0)
                    begin
                        lm_next = 32'd1;
                    end
                    else if (mean > DIV_NUM_W'(ONE_Q30))
                    begin
                        lm_next = ONE_Q30;
                    end
                    else
                    begin
                        lm_next = mean[31:0];
                    end
                    le_next      = 5'd30;
                    lfrac_next   = '0;
                    lit_next     = '0;
                    log_sel_next = LOG_LEQ;
                end
            end
            S_LEQM:
            begin
                mul_a = 32'(neg);
                mul_b = LEQ_PER_LOG2;
            end
            S_LEQW:
            begin
                leq_next = (red > 12'(maxl_reg)) ? '0 : LEVEL_W'(12'(maxl_reg) - red);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        log_sel_reg <= log_sel_next;
        rd_idx_reg  <= rd_idx_next;
        rem_reg     <= rem_next;
        maxl_reg    <= maxl_next;
        cur_lvl_reg <= cur_lvl_next;
        lvl_reg     <= lvl_next;
        leq_reg     <= leq_next;
        l10_reg     <= l10_next;
        lm_reg      <= lm_next;
        le_reg      <= le_next;
        lfrac_reg   <= lfrac_next;
        lit_reg     <= lit_next;
        hv_reg      <= hv_next;
        acc_reg     <= acc_next;
        rank_reg    <= rank_next;
        found_reg   <= found_next;
        h_reg       <= h_next;
        ip_reg      <= ip_next;
        fr_reg      <= fr_next;
        k_reg       <= k_next;
        w_reg       <= w_next;
        sum_reg     <= sum_next;
    end

    assign in_ready         = (state_reg == S_IDLE);
    assign res_valid        = (state_reg == S_DONE);
    assign res_sample_level = lvl_reg;
    assign res_leq_level    = leq_reg;
    assign res_max_level    = maxl_reg;
    assign res_l10_level    = l10_reg;
    assign res_fill_count   = count_reg;

    a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> count_reg != '0)
        else $error("result with empty window");

    a_hist_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        hist_we |-> (state_reg == S_HCLR || state_reg == S_P1HW))
        else $error("histogram written outside clear or fill pass");

    a_div_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_pass_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_P1HW && rem_reg == FILL_W'(1)) |=> state_reg == S_RANK)
        else $error("window pass did not end after last entry");

endmodule

// ===== design/sliding_window_sound_level_stats_top.sv =====
// Top level: configuration registers, stream ports and result register.
`timescale 1ns / 1ps

// Sound level meter over a sliding window of microphone samples. Each accepted
// sample yields one result with the sample level, Leq, Lmax, L10 and the fill
// count, all levels in 1/16 dB. The time one sample occupies the block is set by
// the histogram clear and scan over 2048 level bins, the read-modify-write per
// window entry and the single shared multiplier and divider. s_tready is low
// for the whole of that time; a finished result waits in the output register.
module sliding_window_sound_level_stats_top
#(
    parameter int WINDOW_DEPTH = 8192,
    parameter int ADC_BITS     = 12
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((ADC_BITS + 7) / 8) * 8 - 1:0] s_tdata,   // adc_sample
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // sample_level, leq_level, max_level, l10_level, fill_count
    output logic [swsl_pkg::OUT_DATA_W-1:0]       m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [swsl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [swsl_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    import swsl_pkg::*;

    localparam int BIAS_W = (ADC_BITS > 12) ? ADC_BITS : 12;

    logic [BIAS_W-1:0]       mic_bias_reg;
    logic [FILL_W-1:0]       window_len_reg;
    logic signed [CAL_W-1:0] cal_offset_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic               res_valid, res_ready;
    logic [LEVEL_W-1:0] res_sample_level, res_leq_level, res_max_level, res_l10_level;
    logic [FILL_W-1:0]  res_fill_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mic_bias_reg   <= BIAS_W'(MIC_BIAS_RESET);
            window_len_reg <= WINDOW_LEN_RESET;
            cal_offset_reg <= CAL_OFFSET_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIC_BIAS:   mic_bias_reg   <= BIAS_W'(cfg_wdata[ADC_BITS-1:0]);
                CFG_WINDOW_LEN: window_len_reg <= cfg_wdata[FILL_W-1:0];
                CFG_CAL_OFFSET: cal_offset_reg <= cfg_wdata[CAL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    swsl_core
    #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .ADC_BITS     (ADC_BITS)
    )
    u_core
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_sample        (s_tdata[ADC_BITS-1:0]),
        .mic_bias         (mic_bias_reg),
        .window_len       (window_len_reg),
        .cal_offset       (cal_offset_reg),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res_sample_level (res_sample_level),
        .res_leq_level    (res_leq_level),
        .res_max_level    (res_max_level),
        .res_l10_level    (res_l10_level),
        .res_fill_count   (res_fill_count)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= {6'b0, res_fill_count, res_l10_level, res_max_level,
                             res_leq_level, res_sample_level};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== tb/sliding_window_sound_level_stats_checker.sv =====
// Checker: predicts sound level results from the observed channels and compares them.
`timescale 1ns / 1ps

module sliding_window_sound_level_stats_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [swsl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swsl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int          mismatch_count,
    output int          readings_pending,
    output int          readings_seen
);
    import swsl_pkg::*;

    localparam int DEPTH = 8192;
    localparam int PEND_DEPTH = 16;

    typedef struct packed {
        logic [10:0] sample_level;
        logic [10:0] leq_level;
        logic [10:0] max_level;
        logic [10:0] l10_level;
        logic [13:0] fill_count;
    } reading_t;

    localparam logic [63:0] HALF_STEP [8] = '{
        64'd759250125, 64'd902905651, 64'd984625594, 64'd1028218693,
        64'd1050733751, 64'd1062175488, 64'd1067943006, 64'd1070838491
    };

    logic [11:0] bias_reg;
    logic [13:0] wlen_reg;
    logic signed [10:0] cal_reg;
    logic [10:0] levels [DEPTH];
    int unsigned wr_ptr;
    int unsigned fill;
    reading_t pend_buf [PEND_DEPTH];
    int unsigned pend_head;
    int unsigned pend_tail;
    int unsigned pend_cnt;

    function automatic logic [31:0] log2_q16(input logic [31:0] a);
        int e;
        logic [63:0] m;
        logic [15:0] f;
        if (a == 0)
            a = 1;
        e = 0;
        f = '0;
        while (e < 31 && (a >> (e + 1)) != 0)
            e++;
        if (e <= 30)
            m = 64'(a) << (30 - e);
        else
            m = 64'(a) >> (e - 30);
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            f = {f[14:0], 1'b0};
            if (m >= 64'd2147483648)
            begin
                m = m >> 1;
                f[0] = 1'b1;
            end
        end
        return (32'(e) << 16) | 32'(f);
    endfunction

    function automatic logic [63:0] power_weight(input logic [31:0] x);
        logic [63:0] w;
        w = 64'd1073741824;
        for (int k = 0; k < 8; k++)
            if (x[7 - k])
                w = (w * HALF_STEP[k] + 64'd536870912) >> 30;
        if ((x >> 8) >= 31)
            return 0;
        return w >> (x >> 8);
    endfunction

    function automatic logic [10:0] entry(input int unsigned age);
        return levels[(wr_ptr + DEPTH - 1 - age) % DEPTH];
    endfunction

    function automatic reading_t predict_reading(input logic [11:0] sample);
        reading_t r;
        int unsigned amp, len, maxl, rank, acc, l10;
        longint lvl, leq;
        logic [63:0] sum, mean, neg, red, d, x;
        int unsigned hist [2048];
        amp = (sample >= bias_reg) ? sample - bias_reg : bias_reg - sample;
        if (amp == 0)
            amp = 1;
        lvl = longint'(cal_reg)
            + longint'((64'(log2_q16(amp)) * 64'd6313057 + 64'h80000000) >> 32);
        if (lvl < 0)
            lvl = 0;
        if (lvl > 2047)
            lvl = 2047;
        len = wlen_reg;
        if (len < 1)
            len = 1;
        if (len > DEPTH)
            len = DEPTH;
        levels[wr_ptr] = lvl[10:0];
        wr_ptr = (wr_ptr + 1) % DEPTH;
        fill = fill + 1;
        if (fill > len)
            fill = len;
        foreach (hist[i])
            hist[i] = 0;
        maxl = 0;
        for (int unsigned i = 0; i < fill; i++)
        begin
            hist[entry(i)]++;
            if (entry(i) > maxl)
                maxl = entry(i);
        end
        sum = 0;
        for (int unsigned i = 0; i < fill; i++)
        begin
            d = maxl - entry(i);
            x = (d * 64'd348329 + 64'd32768) >> 16;
            sum = sum + power_weight(x[31:0]);
        end
        mean = sum / fill;
        if (mean == 0)
            mean = 1;
        if (mean > 64'd1073741824)
            mean = 64'd1073741824;
        neg = (64'd30 << 16) - 64'(log2_q16(mean[31:0]));
        red = (neg * 64'd3156528 + 64'h80000000) >> 32;
        leq = longint'(maxl) - longint'(red);
        if (leq < 0)
            leq = 0;
        rank = (fill * 9) / 10;
        acc = 0;
        l10 = maxl;
        for (int i = 0; i < 2048; i++)
        begin
            acc += hist[i];
            if (acc > rank)
            begin
                l10 = i;
                break;
            end
        end
        r.sample_level = lvl[10:0];
        r.leq_level = leq[10:0];
        r.max_level = maxl[10:0];
        r.l10_level = l10[10:0];
        r.fill_count = fill[13:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        reading_t got;
        if (!rst_n)
        begin
            bias_reg = MIC_BIAS_RESET;
            wlen_reg = WINDOW_LEN_RESET;
            cal_reg = CAL_OFFSET_RESET;
            wr_ptr = 0;
            fill = 0;
            pend_head = 0;
            pend_tail = 0;
            pend_cnt = 0;
            mismatch_count = 0;
            readings_pending = 0;
            readings_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MIC_BIAS:   bias_reg = cfg_wdata[11:0];
                    CFG_WINDOW_LEN: wlen_reg = cfg_wdata[13:0];
                    CFG_CAL_OFFSET: cal_reg = cfg_wdata[10:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got.sample_level = m_tdata[10:0];
                got.leq_level = m_tdata[21:11];
                got.max_level = m_tdata[32:22];
                got.l10_level = m_tdata[43:33];
                got.fill_count = m_tdata[57:44];
                readings_seen++;
                if (pend_cnt == 0)
                begin
                    $error("unexpected result transaction %h", m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = pend_buf[pend_head];
                    pend_head = (pend_head + 1) % PEND_DEPTH;
                    pend_cnt--;
                    if (got.sample_level !== want.sample_level)
                    begin
                        $error("sample_level: expected %0d, got %0d",
                               want.sample_level, got.sample_level);
                        mismatch_count++;
                    end
                    if (got.leq_level !== want.leq_level)
                    begin
                        $error("leq_level: expected %0d, got %0d",
                               want.leq_level, got.leq_level);
                        mismatch_count++;
                    end
                    if (got.max_level !== want.max_level)
                    begin
                        $error("max_level: expected %0d, got %0d",
                               want.max_level, got.max_level);
                        mismatch_count++;
                    end
                    if (got.l10_level !== want.l10_level)
                    begin
                        $error("l10_level: expected %0d, got %0d",
                               want.l10_level, got.l10_level);
                        mismatch_count++;
                    end
                    if (got.fill_count !== want.fill_count)
                    begin
                        $error("fill_count: expected %0d, got %0d",
                               want.fill_count, got.fill_count);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                pend_buf[pend_tail] = predict_reading(s_tdata[11:0]);
                pend_tail = (pend_tail + 1) % PEND_DEPTH;
                pend_cnt++;
            end
            readings_pending = pend_cnt;
        end
    end

endmodule

// ===== tb/sliding_window_sound_level_stats_top_tb.sv =====
// Testbench top: stimulus, idling control and verdict for the sound level block.
`timescale 1ns / 1ps

module sliding_window_sound_level_stats_top_tb;
    import swsl_pkg::*;

    localparam longint CYCLE_LIMIT = 20000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_MIC_BIAS;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int     mismatch_count;
    int     readings_pending;
    int     readings_seen;
    int     send_idle_pct = 25;
    int     recv_idle_pct = 63;
    int     samples_sent = 0;
    longint cycles = 0;

    always #4 clk = ~clk;

    sliding_window_sound_level_stats_top DUT
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    sliding_window_sound_level_stats_checker checker_inst
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .mismatch_count(mismatch_count), .readings_pending(readings_pending),
        .readings_seen(readings_seen)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic send_sample(input logic [15:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do
            @(posedge clk);
        while (!s_tready);
        samples_sent++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (readings_pending != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_all(input logic [15:0] bias, input logic [15:0] wlen,
                           input logic [15:0] cal);
        drain();
        write_reg(CFG_MIC_BIAS, bias);
        write_reg(CFG_WINDOW_LEN, wlen);
        write_reg(CFG_CAL_OFFSET, cal);
    endtask

    task automatic random_run(input int n, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < n; i++)
        begin
            if (i % 10 == 0)
                send_sample(16'($urandom));
            else
                send_sample({4'($urandom), 12'($urandom_range(4095))});
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero amplitude, both rails, bits above the converter
        send_sample(16'd1920);
        send_sample(16'd0);
        send_sample(16'd4095);
        send_sample(16'd1921);
        send_sample(16'd1919);
        send_sample(16'hF780);
        send_sample(16'h0FFF);

        // low saturation, short window
        set_all(16'hF000, 16'd4, 16'h0400);
        send_sample(16'd0);
        send_sample(16'd4095);
        send_sample(16'd1);
        send_sample(16'd2048);
        send_sample(16'd0);

        // high saturation, single-entry window
        set_all(16'h0FFF, 16'd1, 16'h03FF);
        send_sample(16'd0);
        send_sample(16'd4095);
        send_sample(16'd4094);

        // zero window length behaves as one
        set_all(16'd2048, 16'd0, 16'd0);
        send_sample(16'd0);
        send_sample(16'd2048);
        send_sample(16'd4095);

        // window length above depth, growing window
        set_all(16'd2048, 16'h3FFF, 16'd160);
        random_run(30, 25, 63);

        // shrink the window
        set_all(16'($urandom), 16'd5, 16'($urandom));
        random_run(25, 63, 25);

        set_all(16'($urandom), 16'd12, 16'($urandom));
        random_run(50, 0, 0);

        drain();
        repeat (200) @(posedge clk);
        $display("Sent %0d samples over seven register settings, %0d results checked.",
                 samples_sent, readings_seen);
        $display("Covered saturation at both ends, zero amplitude, window clamps and shrink.");
        if (mismatch_count == 0 && readings_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/swsl_pkg.sv
design/swsl_mul.sv
design/swsl_div.sv
design/swsl_core.sv
design/sliding_window_sound_level_stats_top.sv
tb/sliding_window_sound_level_stats_checker.sv
tb/sliding_window_sound_level_stats_top_tb.sv
